[rtl/hkr_pkg.sv]
// Shared types and constants for the keyboard report table.
package hkr_pkg;

    localparam int CODE_W      = 8;
    localparam int SHOWN_SLOTS = 6;

    localparam logic [CODE_W-1:0] MOD_FIRST = 8'hE0;
    localparam logic [CODE_W-1:0] MOD_BIT   = 8'h01;

    typedef enum logic [1:0] {
        ACT_PRESS       = 2'd0,
        ACT_RELEASE     = 2'd1,
        ACT_RELEASE_ALL = 2'd2
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [CODE_W-1:0] keycode;
    } event_t;

    typedef struct packed {
        logic              sent;
        logic [CODE_W-1:0] mods;
    } upd_t;

endpackage

[rtl/hkr_if.sv]
// Request and report channel interfaces for the keyboard report table.
interface hkr_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] keycode;

    modport source (output valid, output action, output keycode, input ready);
    modport sink   (input valid, input action, input keycode, output ready);
endinterface

interface hkr_report_if;
    logic       valid;
    logic       ready;
    logic       sent;
    logic [7:0] modifier_mask;
    logic [7:0] slot_0;
    logic [7:0] slot_1;
    logic [7:0] slot_2;
    logic [7:0] slot_3;
    logic [7:0] slot_4;
    logic [7:0] slot_5;

    modport source (
        output valid, output sent, output modifier_mask,
        output slot_0, output slot_1, output slot_2,
        output slot_3, output slot_4, output slot_5,
        input  ready
    );
    modport sink (
        input  valid, input sent, input modifier_mask,
        input  slot_0, input slot_1, input slot_2,
        input  slot_3, input slot_4, input slot_5,
        output ready
    );
endinterface

[rtl/hkr_event_reg.sv]
// Input register stage that captures one key request.
module hkr_event_reg (
    input  logic            clk,
    input  logic            rst_n,
    hkr_event_if.sink       key_event,
    input  logic            free,
    output logic            item_valid,
    output hkr_pkg::event_t item
);
    import hkr_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t item_reg;
    event_t item_next;
    logic   accept;

    assign key_event.ready = !valid_reg || free;
    assign accept          = key_event.valid && key_event.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next        = 1'b1;
            item_next.action  = action_t'(key_event.action);
            item_next.keycode = key_event.keycode;
        end
        else if (free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/hkr_update.sv]
// Next-report logic: modifier update, slot insert, slot clear and compaction.
module hkr_update #(
    parameter int KEY_SLOTS = 6
) (
    input  hkr_pkg::event_t                      item,
    input  logic [KEY_SLOTS-1:0][7:0]            keys,
    input  logic [7:0]                           mods,
    output logic [KEY_SLOTS-1:0][7:0]            keys_next,
    output hkr_pkg::upd_t                        upd
);
    import hkr_pkg::*;

    localparam int RANK_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic                             is_mod;
    logic [CODE_W-1:0]                mod_bit;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] ins_keys;
    logic                             ins_ok;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] clr_keys;
    logic [KEY_SLOTS-1:0]             nz;
    logic [KEY_SLOTS-1:0][RANK_W-1:0] rank;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] rel_keys;

    assign is_mod  = (item.keycode[7:3] == MOD_FIRST[7:3]);
    assign mod_bit = MOD_BIT << item.keycode[2:0];

    // first slot that matches or is empty; write only when empty
    always_comb
    begin
        ins_keys = keys;
        ins_ok   = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (!ins_ok && (keys[i] == item.keycode || keys[i] == '0))
            begin
                ins_ok = 1'b1;
                if (keys[i] != item.keycode)
                begin
                    ins_keys[i] = item.keycode;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            clr_keys[i] = (keys[i] == item.keycode) ? '0 : keys[i];
            nz[i]       = (clr_keys[i] != '0);
        end
        rank[0] = '0;
        for (int i = 1; i < KEY_SLOTS; i++)
        begin
            rank[i] = rank[i-1] + RANK_W'(nz[i-1]);
        end
    end

    // move each nonzero code to the slot given by its rank
    always_comb
    begin
        rel_keys = '0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if (nz[i] && rank[i] == RANK_W'(j))
                begin
                    rel_keys[j] = clr_keys[i];
                end
            end
        end
    end

    always_comb
    begin
        keys_next = keys;
        upd.mods  = mods;
        upd.sent  = 1'b0;
        unique case (item.action)
            ACT_PRESS:
            begin
                if (is_mod)
                begin
                    upd.mods = mods | mod_bit;
                    upd.sent = 1'b1;
                end
                else
                begin
                    keys_next = ins_keys;
                    upd.sent  = ins_ok;
                end
            end
            ACT_RELEASE:
            begin
                upd.sent = 1'b1;
                if (is_mod)
                begin
                    upd.mods = mods & ~mod_bit;
                end
                else
                begin
                    keys_next = rel_keys;
                end
            end
            ACT_RELEASE_ALL:
            begin
                keys_next = '0;
                upd.mods  = '0;
                upd.sent  = 1'b1;
            end
            default:
            begin
                upd.sent = 1'b0;
            end
        endcase
    end

endmodule

[rtl/hkr_report_reg.sv]
// Report register: held modifiers and key slots, result valid and sent flag.
module hkr_report_reg #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  hkr_pkg::event_t            item,
    input  hkr_pkg::upd_t              upd,
    input  logic [KEY_SLOTS-1:0][7:0]  keys_next,
    output logic                       free,
    output logic [KEY_SLOTS-1:0][7:0]  keys,
    output logic [7:0]                 mods,
    hkr_report_if.source               report
);
    import hkr_pkg::*;

    localparam int SHOW_N = (KEY_SLOTS < SHOWN_SLOTS) ? KEY_SLOTS : SHOWN_SLOTS;

    logic                             valid_reg;
    logic                             valid_next;
    logic                             sent_reg;
    logic [CODE_W-1:0]                mods_reg;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] keys_reg;
    logic                             take;
    logic [SHOWN_SLOTS-1:0][CODE_W-1:0] shown;

    assign free = !valid_reg || report.ready;
    assign take = item_valid && free;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
            mods_reg  <= '0;
            keys_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                sent_reg <= upd.sent;
                mods_reg <= upd.mods;
                keys_reg <= keys_next;
            end
        end
    end

    always_comb
    begin
        shown = '0;
        for (int j = 0; j < SHOW_N; j++)
        begin
            shown[j] = keys_reg[j];
        end
    end

    assign keys                 = keys_reg;
    assign mods                 = mods_reg;
    assign report.valid         = valid_reg;
    assign report.sent          = sent_reg;
    assign report.modifier_mask = mods_reg;
    assign report.slot_0        = shown[0];
    assign report.slot_1        = shown[1];
    assign report.slot_2        = shown[2];
    assign report.slot_3        = shown[3];
    assign report.slot_4        = shown[4];
    assign report.slot_5        = shown[5];

`ifndef NO_ASSERTIONS
    a_release_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.action == ACT_RELEASE_ALL |=> mods_reg == '0 && keys_reg == '0 && sent_reg)
        else $error("release all did not clear the report");

    a_mod_press_sets: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.action == ACT_PRESS && item.keycode[7:3] == MOD_FIRST[7:3]
        |=> sent_reg && mods_reg[$past(item.keycode[2:0])])
        else $error("modifier press did not set its bit");

    a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take && !upd.sent |=> $stable(keys_reg) && $stable(mods_reg))
        else $error("failed request changed the report");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("taken request left no result");
`endif

endmodule

[rtl/hid_keyboard_report_table.sv]
// Top level of the USB boot keyboard report table (modifier mask and key slots).
// Each key request (press, release, release all) passes an input register
// and updates the report register, so one request is taken every clock while
// the report channel keeps up; a stalled report channel backs up into ready.
// Its result appears on the report channel and holds until taken, while the
// next request may already wait in the input register. The combinational slot
// match, insert and compaction network feeding the report register sets the rate.
module hid_keyboard_report_table #(
    parameter int KEY_SLOTS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    hkr_event_if.sink     key_event,
    hkr_report_if.source  report
);
    import hkr_pkg::*;

    logic                             item_valid;
    event_t                           item;
    logic                             free;
    upd_t                             upd;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] keys;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] keys_next;
    logic [CODE_W-1:0]                mods;

    hkr_event_reg u_event_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_event  (key_event),
        .free       (free),
        .item_valid (item_valid),
        .item       (item)
    );

    hkr_update #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_update (
        .item      (item),
        .keys      (keys),
        .mods      (mods),
        .keys_next (keys_next),
        .upd       (upd)
    );

    hkr_report_reg #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_report_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .upd        (upd),
        .keys_next  (keys_next),
        .free       (free),
        .keys       (keys),
        .mods       (mods),
        .report     (report)
    );

endmodule
